// ----- hdl/apt_pkg.sv -----
`default_nettype none
package apt_pkg;

    localparam int COORD_BITS_DEF = 21;
    localparam int COEF_BITS_DEF  = 16;
    localparam int ADDR_BITS      = 6;
    localparam int DATA_BITS      = 64;
    localparam int ROW_BITS       = 48;
    localparam int VEC_BITS       = 63;

    localparam logic [2:0] REG_ROT0  = 3'd0;
    localparam logic [2:0] REG_ROT1  = 3'd1;
    localparam logic [2:0] REG_ROT2  = 3'd2;
    localparam logic [2:0] REG_STR0  = 3'd3;
    localparam logic [2:0] REG_STR1  = 3'd4;
    localparam logic [2:0] REG_STR2  = 3'd5;
    localparam logic [2:0] REG_TRANS = 3'd6;
    localparam logic [2:0] REG_REF   = 3'd7;

    localparam logic [1:0] LAST_IDX  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MACQ,
        ST_MACE,
        ST_ROUND,
        ST_EMIT_PT,
        ST_EMIT_BOX
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MACQ,
        OP_MACE,
        OP_ROUND,
        OP_EMIT_PT,
        OP_EMIT_BOX
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] row;
        logic [1:0] col;
    } cmd_t;

    typedef struct packed {
        logic final_pt;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- hdl/apt_regs.sv -----
`default_nettype none
module apt_regs #(
    parameter int COEF_BITS = apt_pkg::COEF_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [apt_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [apt_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [apt_pkg::DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [2:0][apt_pkg::ROW_BITS-1:0]   rot,
    output logic [2:0][apt_pkg::ROW_BITS-1:0]   str,
    output logic      [apt_pkg::VEC_BITS-1:0]   trans,
    output logic      [apt_pkg::VEC_BITS-1:0]   refp
);
    import apt_pkg::*;

    logic [2:0][ROW_BITS-1:0] rot_reg;
    logic [2:0][ROW_BITS-1:0] str_reg;
    logic [VEC_BITS-1:0]      trans_reg;
    logic [VEC_BITS-1:0]      ref_reg;
    logic [2:0]               idx;
    logic                     wr;

    assign idx    = paddr[ADDR_BITS-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rot_reg[i] <= ROW_BITS'(1) << (i * COEF_BITS + COEF_BITS - 2);
                str_reg[i] <= '0;
            end
            trans_reg <= '0;
            ref_reg   <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_ROT0:  rot_reg[0] <= pwdata[ROW_BITS-1:0];
                REG_ROT1:  rot_reg[1] <= pwdata[ROW_BITS-1:0];
                REG_ROT2:  rot_reg[2] <= pwdata[ROW_BITS-1:0];
                REG_STR0:  str_reg[0] <= pwdata[ROW_BITS-1:0];
                REG_STR1:  str_reg[1] <= pwdata[ROW_BITS-1:0];
                REG_STR2:  str_reg[2] <= pwdata[ROW_BITS-1:0];
                REG_TRANS: trans_reg  <= pwdata[VEC_BITS-1:0];
                REG_REF:   ref_reg    <= pwdata[VEC_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROT0:  prdata = DATA_BITS'(rot_reg[0]);
            REG_ROT1:  prdata = DATA_BITS'(rot_reg[1]);
            REG_ROT2:  prdata = DATA_BITS'(rot_reg[2]);
            REG_STR0:  prdata = DATA_BITS'(str_reg[0]);
            REG_STR1:  prdata = DATA_BITS'(str_reg[1]);
            REG_STR2:  prdata = DATA_BITS'(str_reg[2]);
            REG_TRANS: prdata = DATA_BITS'(trans_reg);
            REG_REF:   prdata = DATA_BITS'(ref_reg);
        endcase
    end

    assign rot   = rot_reg;
    assign str   = str_reg;
    assign trans = trans_reg;
    assign refp  = ref_reg;

endmodule
`default_nettype wire

// ----- hdl/apt_ctrl.sv -----
`default_nettype none
module apt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire apt_pkg::status_t status,
    output apt_pkg::cmd_t         cmd
);
    import apt_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MACQ;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_MACQ:
            begin
                if (col_reg == LAST_IDX)
                begin
                    col_next = '0;
                    if (row_reg == LAST_IDX)
                    begin
                        row_next   = '0;
                        state_next = ST_MACE;
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                    end
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_MACE:
            begin
                if (col_reg == LAST_IDX)
                begin
                    col_next   = '0;
                    state_next = ST_ROUND;
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_ROUND:
            begin
                if (row_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT_PT;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = ST_MACE;
                end
            end
            ST_EMIT_PT:
            begin
                if (status.out_free)
                begin
                    state_next = status.final_pt ? ST_EMIT_BOX : ST_IDLE;
                end
            end
            ST_EMIT_BOX:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NOP;
        cmd.row  = row_reg;
        cmd.col  = col_reg;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_MACQ:     cmd.op = OP_MACQ;
            ST_MACE:     cmd.op = OP_MACE;
            ST_ROUND:    cmd.op = OP_ROUND;
            ST_EMIT_PT:  cmd.op = status.out_free ? OP_EMIT_PT : OP_NOP;
            ST_EMIT_BOX: cmd.op = status.out_free ? OP_EMIT_BOX : OP_NOP;
            default:     cmd.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/apt_datapath.sv -----
`default_nettype none
module apt_datapath #(
    parameter int COORD_BITS = apt_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = apt_pkg::COEF_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire apt_pkg::cmd_t                       cmd,
    output apt_pkg::status_t                         status,
    input  wire logic [2:0][apt_pkg::ROW_BITS-1:0]   rot,
    input  wire logic [2:0][apt_pkg::ROW_BITS-1:0]   str,
    input  wire logic      [apt_pkg::VEC_BITS-1:0]   trans,
    input  wire logic      [apt_pkg::VEC_BITS-1:0]   refp,
    input  wire logic signed [COORD_BITS-1:0]        pos_x,
    input  wire logic signed [COORD_BITS-1:0]        pos_y,
    input  wire logic signed [COORD_BITS-1:0]        pos_z,
    input  wire logic                                final_point,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     kind,
    output logic signed [COORD_BITS-1:0]             out_x,
    output logic signed [COORD_BITS-1:0]             out_y,
    output logic signed [COORD_BITS-1:0]             out_z,
    output logic signed [COORD_BITS-1:0]             box_max_x,
    output logic signed [COORD_BITS-1:0]             box_max_y,
    output logic signed [COORD_BITS-1:0]             box_max_z,
    output logic                                     saturated,
    output logic                                     end_of_run
);
    import apt_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int KB = COEF_BITS;
    localparam int CF = KB - 2;
    localparam int DW = CB + 1;
    localparam int QW = KB + CB + 3;
    localparam int EW = KB + QW + 2;
    localparam int TW = EW + 2;
    localparam int SH = 2 * CF;
    localparam int RW = TW - SH;

    localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] CMIN = RW'(-(64'sd1 <<< (CB - 1)));

    logic signed [2:0][CB-1:0] pos;
    logic signed [CB-1:0]      ref_f   [3];
    logic signed [CB-1:0]      trans_f [3];

    logic signed [DW-1:0] d_reg [3];
    logic signed [QW-1:0] q_reg [3];
    logic signed [EW-1:0] acc_reg;
    logic                 final_reg;
    logic signed [CB-1:0] p_reg  [3];
    logic                 sat_reg;
    logic signed [CB-1:0] lo_reg [3];
    logic signed [CB-1:0] hi_reg [3];
    logic                 started_reg;

    logic                 out_valid_reg;
    logic                 kind_reg;
    logic signed [CB-1:0] out_reg [3];
    logic signed [CB-1:0] max_reg [3];
    logic                 osat_reg;
    logic                 eor_reg;

    logic signed [KB-1:0] coef;
    logic signed [EW-1:0] coef_x, opnd_x, prod, acc_next;
    logic signed [DW-1:0] base;
    logic signed [TW-1:0] total;
    logic signed [RW-1:0] shifted;
    logic signed [CB-1:0] p_new;
    logic                 sat_new;

    assign pos = {pos_z, pos_y, pos_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ref_f[i]   = $signed(refp[i*CB +: CB]);
            trans_f[i] = $signed(trans[i*CB +: CB]);
        end
    end

    // One shared multiply-accumulate serves both A*d and S*q.
    always_comb
    begin
        if (cmd.op == OP_MACE)
        begin
            coef   = $signed(str[cmd.row][cmd.col*KB +: KB]);
            opnd_x = EW'(q_reg[cmd.col]);
        end
        else
        begin
            coef   = $signed(rot[cmd.row][cmd.col*KB +: KB]);
            opnd_x = EW'(d_reg[cmd.col]);
        end
        coef_x   = EW'(coef);
        prod     = coef_x * opnd_x;
        acc_next = ((cmd.col == 2'd0) ? '0 : acc_reg) + prod;
    end

    // Round half up at the Q.28 point, then clamp to the coordinate range.
    always_comb
    begin
        base    = DW'(ref_f[cmd.row]) + DW'(trans_f[cmd.row]);
        total   = (TW'(base) <<< SH) + (TW'(q_reg[cmd.row]) <<< CF) + TW'(acc_reg)
                  + (TW'(1) <<< (SH - 1));
        shifted = RW'(total >>> SH);
        sat_new = 1'b0;
        if (shifted > CMAX)
        begin
            p_new   = CMAX[CB-1:0];
            sat_new = 1'b1;
        end
        else if (shifted < CMIN)
        begin
            p_new   = CMIN[CB-1:0];
            sat_new = 1'b1;
        end
        else
        begin
            p_new = shifted[CB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_reg[i] <= DW'($signed(pos[i])) - DW'(ref_f[i]);
                end
                final_reg <= final_point;
                sat_reg   <= 1'b0;
            end
            OP_MACQ:
            begin
                acc_reg <= acc_next;
                if (cmd.col == LAST_IDX)
                begin
                    q_reg[cmd.row] <= acc_next[QW-1:0];
                end
            end
            OP_MACE:
            begin
                acc_reg <= acc_next;
            end
            OP_ROUND:
            begin
                p_reg[cmd.row] <= p_new;
                sat_reg        <= sat_reg | sat_new;
            end
            OP_NOP, OP_EMIT_PT, OP_EMIT_BOX:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_ROUND)
        begin
            if (!started_reg)
            begin
                lo_reg[cmd.row] <= p_new;
                hi_reg[cmd.row] <= p_new;
            end
            else
            begin
                if (p_new < lo_reg[cmd.row])
                begin
                    lo_reg[cmd.row] <= p_new;
                end
                if (p_new > hi_reg[cmd.row])
                begin
                    hi_reg[cmd.row] <= p_new;
                end
            end
            if (cmd.row == LAST_IDX)
            begin
                started_reg <= 1'b1;
            end
        end
        else if (cmd.op == OP_EMIT_BOX)
        begin
            started_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_EMIT_PT || cmd.op == OP_EMIT_BOX)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT_PT)
        begin
            kind_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= p_reg[i];
                max_reg[i] <= '0;
            end
            osat_reg <= sat_reg;
            eor_reg  <= !final_reg;
        end
        else if (cmd.op == OP_EMIT_BOX)
        begin
            kind_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= lo_reg[i];
                max_reg[i] <= hi_reg[i];
            end
            osat_reg <= 1'b0;
            eor_reg  <= 1'b1;
        end
    end

    assign status.final_pt = final_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign out_x      = out_reg[0];
    assign out_y      = out_reg[1];
    assign out_z      = out_reg[2];
    assign box_max_x  = max_reg[0];
    assign box_max_y  = max_reg[1];
    assign box_max_z  = max_reg[2];
    assign saturated  = osat_reg;
    assign end_of_run = eor_reg;

endmodule
`default_nettype wire

// ----- hdl/affine_point_cloud_transform_top.sv -----
`default_nettype none
// Channel   Handshake            Beat contents
// input     in_valid / in_stall  pos_x, pos_y, pos_z, final_point
// output    out_valid/out_stall  kind, out_x..z, box_max_x..z, saturated, end_of_run
// config    APB (psel..pready)   8 registers at byte address 8*i, 64-bit data
//
// One multiplier-accumulator does the 18 coefficient products one per cycle,
// with one rounding step per coordinate. A new point is accepted only once the
// previous one has emitted its result beat, and after a final point also its
// box beat, which follows the point beat.
// Reset restores the identity rotation, zero strain and an empty box.
// A stalled output beat holds the block before it writes the next result.
module affine_point_cloud_transform_top #(
    parameter int COORD_BITS = apt_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = apt_pkg::COEF_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [apt_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [apt_pkg::DATA_BITS-1:0]      pwdata,
    output logic      [apt_pkg::DATA_BITS-1:0]      prdata,
    output logic                                    pready,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [COORD_BITS-1:0]       pos_x,
    input  wire logic signed [COORD_BITS-1:0]       pos_y,
    input  wire logic signed [COORD_BITS-1:0]       pos_z,
    input  wire logic                               final_point,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    kind,
    output logic signed [COORD_BITS-1:0]            out_x,
    output logic signed [COORD_BITS-1:0]            out_y,
    output logic signed [COORD_BITS-1:0]            out_z,
    output logic signed [COORD_BITS-1:0]            box_max_x,
    output logic signed [COORD_BITS-1:0]            box_max_y,
    output logic signed [COORD_BITS-1:0]            box_max_z,
    output logic                                    saturated,
    output logic                                    end_of_run
);
    import apt_pkg::*;

    logic [2:0][ROW_BITS-1:0] rot;
    logic [2:0][ROW_BITS-1:0] str;
    logic [VEC_BITS-1:0]      trans;
    logic [VEC_BITS-1:0]      refp;
    cmd_t                     cmd;
    status_t                  status;

    apt_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rot     (rot),
        .str     (str),
        .trans   (trans),
        .refp    (refp)
    );

    apt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    apt_datapath #(
        .COORD_BITS (COORD_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .rot         (rot),
        .str         (str),
        .trans       (trans),
        .refp        (refp),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .final_point (final_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z),
        .saturated   (saturated),
        .end_of_run  (end_of_run)
    );

endmodule
`default_nettype wire
